// ===== hdl/frt_pkg.sv =====
`default_nettype none

package frt_pkg;

  // Slot count is a power of two; the slot index is the low bits of the frame number.
  localparam int unsigned SLOT_W  = 2;
  localparam int unsigned SLOTS   = 1 << SLOT_W;

  localparam int unsigned FRAME_W = 31;
  localparam int unsigned OFF_W   = 23;
  localparam int unsigned LEN_W   = 11;
  localparam int unsigned CNT_W   = 15;
  localparam int unsigned AGE_W   = 2;

  localparam logic [31:0] FRAME_BYTES = 32'd8388608;
  localparam logic [31:0] MAX_PAYLOAD = 32'd1484;
  localparam logic [AGE_W-1:0] AGE_RESET = 2'd2;

  typedef enum logic [1:0] {
    DROP_NONE = 2'd0,
    DROP_OLD  = 2'd1,
    DROP_SIZE = 2'd2
  } drop_e;

  typedef enum logic [1:0] {
    CMPL_NONE  = 2'd0,
    CMPL_DONE  = 2'd1,
    CMPL_STALE = 2'd2
  } cmpl_e;

  // One slot entry as seen by the update logic.
  typedef struct packed {
    logic               busy;
    logic [FRAME_W-1:0] frame;
    logic [CNT_W-1:0]   missing;
  } slot_t;

  // Write-back request from the update stage.
  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] addr;
    slot_t             data;
  } slot_wr_t;

endpackage

`default_nettype wire

// ===== hdl/frt_slot_mem.sv =====
`default_nettype none

module frt_slot_mem (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  wire                       rd_en_i,
  input  wire [frt_pkg::SLOT_W-1:0] rd_addr_i,
  input  frt_pkg::slot_wr_t         wr_i,
  output frt_pkg::slot_t            rd_data_o
);
  import frt_pkg::*;

  localparam int unsigned WORD_W = FRAME_W + CNT_W;

  logic [WORD_W-1:0] mem [SLOTS];
  logic [SLOTS-1:0]  busy_q;

  logic [WORD_W-1:0] rd_word_q;
  logic              rd_busy_q;
  logic              fwd_q;
  slot_t             fwd_data_q;

  // frame number and missing count live in the RAM
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= {wr_i.data.frame, wr_i.data.missing};
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_word_q  <= mem[rd_addr_i];
      fwd_data_q <= wr_i.data;
    end
  end

  // busy bits double as per-entry valid bits, cleared at reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= '0;
      rd_busy_q <= 1'b0;
      fwd_q     <= 1'b0;
    end else begin
      if (wr_i.en) begin
        busy_q[wr_i.addr] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_busy_q <= busy_q[rd_addr_i];
        // write-back to the same entry in the read cycle: take the new word
        fwd_q     <= wr_i.en && (wr_i.addr == rd_addr_i);
      end
    end
  end

  always_comb begin
    if (fwd_q) begin
      rd_data_o = fwd_data_q;
    end else begin
      rd_data_o.busy    = rd_busy_q;
      rd_data_o.frame   = rd_word_q[WORD_W-1:CNT_W];
      rd_data_o.missing = rd_word_q[CNT_W-1:0];
    end
  end

endmodule

`default_nettype wire

// ===== hdl/frame_fragment_reassembly_tracker.sv =====
`default_nettype none

// Fragment reassembly tracker. Pulse start_i with one fragment header. A result word
// drives the result ports for exactly one cycle, marked by done_o. The header is captured
// into the update stage registers at accept, and the result word registers load from
// that stage. busy_o stays low, so a header may be given in every cycle: one
// header per cycle, set by the single read-modify-write pass over the slot RAM (read at
// accept, update and write back in the next cycle, with a bypass when back-to-back
// headers hit the same slot). The receiver cannot stall the result stream, so results
// must be taken when done_o is high. Frames map to slot frame_number mod SLOTS. A
// fragment whose frame is age_limit or more behind the newest frame number is dropped
// as too old; one that runs past the frame buffer or is oversized is dropped for size.
// Dropped fragments change no state and report all-zero write and completion fields.
// Write cfg_wdata_i (age_limit, 0 treated as 1, reset 2) with cfg_we_i while idle.
module frame_fragment_reassembly_tracker (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          start_i,
  output logic                         busy_o,
  input  wire [frt_pkg::FRAME_W-1:0]   frame_number_i,
  input  wire [frt_pkg::OFF_W-1:0]     byte_offset_i,
  input  wire [frt_pkg::LEN_W-1:0]     fragment_length_i,
  input  wire [frt_pkg::CNT_W-1:0]     fragment_count_i,
  input  wire                          cfg_we_i,
  input  wire [frt_pkg::AGE_W-1:0]     cfg_wdata_i,
  output logic                         done_o,
  output logic                         write_enable_o,
  output logic [1:0]                   write_slot_o,
  output logic [frt_pkg::OFF_W-1:0]    write_offset_o,
  output logic [frt_pkg::LEN_W-1:0]    write_length_o,
  output logic [1:0]                   drop_reason_o,
  output logic [1:0]                   completion_o,
  output logic [frt_pkg::FRAME_W-1:0]  done_frame_o
);
  import frt_pkg::*;

  // config and tracker state
  logic [AGE_W-1:0]   age_q;
  logic [FRAME_W-1:0] newest_q, newest_d;

  // update stage: header captured at accept, slot word arrives from RAM
  logic               s1_valid_q;
  logic [FRAME_W-1:0] s1_frame_q;
  logic [OFF_W-1:0]   s1_off_q;
  logic [LEN_W-1:0]   s1_len_q;
  logic [CNT_W-1:0]   s1_cnt_q;
  logic [SLOT_W-1:0]  s1_slot;

  slot_t    rd_slot;
  slot_wr_t wr;

  // result word registers
  logic               done_q;
  logic               wen_q;
  logic [1:0]         wslot_q;
  logic [OFF_W-1:0]   woff_q;
  logic [LEN_W-1:0]   wlen_q;
  drop_e              drop_q, drop_d;
  cmpl_e              cmpl_q, cmpl_d;
  logic [FRAME_W-1:0] dframe_q, dframe_d;

  logic               accept;
  logic [AGE_W-1:0]   lim;
  logic [31:0]        old_sum;
  logic               too_old;
  logic               too_big;
  logic               claim;
  logic [CNT_W-1:0]   miss0;
  logic [CNT_W-1:0]   miss1;

  assign busy_o  = 1'b0;
  assign accept  = start_i && !busy_o;
  assign s1_slot = s1_frame_q[SLOT_W-1:0];

  frt_slot_mem u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (accept),
    .rd_addr_i (frame_number_i[SLOT_W-1:0]),
    .wr_i      (wr),
    .rd_data_o (rd_slot)
  );

  // --- update stage ---------------------------------------------------------
  always_comb begin
    lim     = (age_q == '0) ? AGE_W'(1) : age_q;
    old_sum = 32'(s1_frame_q) + 32'(lim);
    too_old = old_sum <= 32'(newest_q);
    too_big = ((32'(s1_off_q) + 32'(s1_len_q)) > FRAME_BYTES) ||
              (32'(s1_len_q) > MAX_PAYLOAD);

    // a new frame id (or a free slot) restarts the missing count
    claim = !rd_slot.busy || (rd_slot.frame != s1_frame_q);
    if (claim) begin
      miss0 = (s1_cnt_q == '0) ? CNT_W'(1) : s1_cnt_q;
    end else begin
      miss0 = rd_slot.missing;
    end
    miss1 = (miss0 != '0) ? (miss0 - CNT_W'(1)) : miss0;

    newest_d = newest_q;
    drop_d   = DROP_NONE;
    cmpl_d   = CMPL_NONE;
    dframe_d = '0;
    wr.en    = 1'b0;
    wr.addr  = s1_slot;
    wr.data.busy    = 1'b1;
    wr.data.frame   = s1_frame_q;
    wr.data.missing = miss1;

    priority if (!s1_valid_q) begin
      drop_d = DROP_NONE;
    end else if (too_old) begin
      drop_d = DROP_OLD;
    end else if (too_big) begin
      drop_d = DROP_SIZE;
    end else begin
      wr.en = 1'b1;
      if (s1_frame_q > newest_q) begin
        newest_d = s1_frame_q;
      end
      // count just hit zero: done, or stale when a newer frame was seen
      if (miss0 != '0 && miss1 == '0) begin
        cmpl_d   = (s1_frame_q >= newest_q) ? CMPL_DONE : CMPL_STALE;
        dframe_d = s1_frame_q;
      end
    end
  end

  // --- control registers ----------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      age_q      <= AGE_RESET;
      newest_q   <= '0;
      s1_valid_q <= 1'b0;
      done_q     <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        age_q <= cfg_wdata_i;
      end
      newest_q   <= newest_d;
      s1_valid_q <= accept;
      done_q     <= s1_valid_q;
    end
  end

  // --- payload registers ----------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_frame_q <= frame_number_i;
      s1_off_q   <= byte_offset_i;
      s1_len_q   <= fragment_length_i;
      s1_cnt_q   <= fragment_count_i;
    end
    if (s1_valid_q) begin
      wen_q    <= wr.en;
      wslot_q  <= wr.en ? 2'(s1_slot) : 2'd0;
      woff_q   <= wr.en ? s1_off_q : '0;
      wlen_q   <= wr.en ? s1_len_q : '0;
      drop_q   <= drop_d;
      cmpl_q   <= cmpl_d;
      dframe_q <= dframe_d;
    end
  end

  assign done_o         = done_q;
  assign write_enable_o = wen_q;
  assign write_slot_o   = wslot_q;
  assign write_offset_o = woff_q;
  assign write_length_o = wlen_q;
  assign drop_reason_o  = drop_q;
  assign completion_o   = cmpl_q;
  assign done_frame_o   = dframe_q;

`ifndef SYNTHESIS
  a_accept_to_stage : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> s1_valid_q)
    else $error("accepted header did not enter update stage");

  a_stage_to_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q |=> done_o)
    else $error("update stage produced no result word");

  a_drop_no_write : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && drop_reason_o != DROP_NONE) |-> (!write_enable_o && completion_o == CMPL_NONE))
    else $error("dropped fragment issued a write or completion");

  a_no_cmpl_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && completion_o == CMPL_NONE) |-> (done_frame_o == '0))
    else $error("done_frame nonzero without completion");

  a_newest_monotonic : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q |=> (newest_q >= $past(newest_q)))
    else $error("newest frame number went backward");
`endif

endmodule

`default_nettype wire
